### rtl/rle8d_pkg.sv
// ----------------------------------------------------------------------------
// RLE8 bitmap decoder package
// Shared widths, escape codes, register indexes and word types.
// ----------------------------------------------------------------------------
package rle8d_pkg;

   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;

   localparam int BYTE_W = 8;
   localparam int DIM_W  = 13;
   localparam int COL_W  = 12;
   localparam int LEN_W  = 25;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'h00;
   localparam logic [BYTE_W-1:0] ESC_EOL   = 8'h00;
   localparam logic [BYTE_W-1:0] ESC_EOB   = 8'h01;
   localparam logic [BYTE_W-1:0] ESC_DELTA = 8'h02;

   typedef struct packed {
      logic [BYTE_W-1:0] pixel_index;
      logic [LEN_W-1:0]  run_length;
      logic              image_done;
   } result_type;

   typedef struct packed {
      logic                   wr_en;
      logic [CSR_INDEX_W-1:0] index;
      logic [DIM_W-1:0]       data;
   } csr_write_type;

endpackage

### rtl/rle8d_req_if.sv
// ----------------------------------------------------------------------------
// RLE8 decoder request channel
// Valid/ready channel carrying one compressed byte per word.
// ----------------------------------------------------------------------------
interface rle8d_req_if;
   logic                         valid;
   logic                         ready;
   logic [rle8d_pkg::BYTE_W-1:0] data_byte;
   logic                         last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

### rtl/rle8d_rsp_if.sv
// ----------------------------------------------------------------------------
// RLE8 decoder response channel
// Valid/ready channel carrying one pixel run per word.
// ----------------------------------------------------------------------------
interface rle8d_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [rle8d_pkg::BYTE_W-1:0] pixel_index;
   logic [rle8d_pkg::LEN_W-1:0]  run_length;
   logic                         image_done;

   modport source (output valid, output pixel_index, output run_length,
                   output image_done, input ready);
   modport sink   (input valid, input pixel_index, input run_length,
                   input image_done, output ready);
endinterface

### rtl/rle8d_engine.sv
// ----------------------------------------------------------------------------
// RLE8 decode engine
// Phase machine, position counters and size registers; turns one accepted
// byte per cycle into at most one run word.
// ----------------------------------------------------------------------------
module rle8d_engine (
   input  logic                         clock,
   input  logic                         reset,
   input  rle8d_pkg::csr_write_type     csr,
   input  logic                         step,
   input  logic [rle8d_pkg::BYTE_W-1:0] data_byte,
   input  logic                         last_byte,
   output logic                         res_valid,
   output rle8d_pkg::result_type        res
);

   typedef enum logic [5:0] {
      PH_COUNT = 6'b000001,
      PH_VALUE = 6'b000010,
      PH_CODE  = 6'b000100,
      PH_DX    = 6'b001000,
      PH_DY    = 6'b010000,
      PH_ABS   = 6'b100000
   } phase_type;

   localparam int DIV_HI_W = 5;
   localparam int DIV_LO_W = 4;
   localparam int DIV_W    = rle8d_pkg::DIM_W + DIV_HI_W + DIV_LO_W - 1;
   localparam int MUL_W    = rle8d_pkg::DIM_W + rle8d_pkg::BYTE_W;

   phase_type                      phase_ff, phase_in;
   logic [rle8d_pkg::BYTE_W-1:0]   held_ff, held_in;
   logic [rle8d_pkg::BYTE_W-1:0]   abs_left_ff, abs_left_in;
   logic [rle8d_pkg::BYTE_W:0]     skip_left_ff, skip_left_in;
   logic [rle8d_pkg::BYTE_W-1:0]   delta_cols_ff, delta_cols_in;
   logic [rle8d_pkg::DIM_W-1:0]    div_rem_ff, div_rem_in;
   logic [DIV_HI_W-1:0]            div_qhi_ff, div_qhi_in;
   logic [rle8d_pkg::COL_W-1:0]    column_ff, column_in;
   logic [rle8d_pkg::DIM_W-1:0]    row_ff, row_in;
   logic                           finished_ff, finished_in;
   logic [rle8d_pkg::DIM_W-1:0]    width_ff, width_in;
   logic [rle8d_pkg::DIM_W-1:0]    height_ff, height_in;
   logic [rle8d_pkg::LEN_W-1:0]    pix_left_ff, pix_left_in;

   logic [rle8d_pkg::DIM_W-1:0]    row_left;
   logic [rle8d_pkg::DIM_W-1:0]    div_rem_hi;
   logic [DIV_HI_W-1:0]            div_q_hi;
   logic [rle8d_pkg::COL_W-1:0]    div_rem_lo;
   logic [DIV_LO_W-1:0]            div_q_lo;
   logic [MUL_W-1:0]               delta_mul;
   logic [rle8d_pkg::LEN_W-1:0]    delta_len;
   logic [rle8d_pkg::DIM_W-1:0]    row_sum;
   logic [rle8d_pkg::DIM_W-1:0]    cfg_w, cfg_h;
   logic [rle8d_pkg::LEN_W-1:0]    cfg_area;
   logic                           have, done;
   logic [rle8d_pkg::BYTE_W-1:0]   idx;
   logic [rle8d_pkg::LEN_W-1:0]    len;

   function automatic logic [rle8d_pkg::DIM_W-1:0] saturate(
      input logic [rle8d_pkg::DIM_W-1:0] v,
      input logic [rle8d_pkg::DIM_W-1:0] top
   );
      logic [rle8d_pkg::DIM_W-1:0] r;
      r = v;
      if (v == '0) r = rle8d_pkg::DIM_W'(1);
      if (v > top) r = top;
      return r;
   endfunction

   assign row_left = (row_ff < height_ff) ? width_ff - rle8d_pkg::DIM_W'(column_ff) : '0;

   // (column + dx) / width, upper quotient bits taken on the dx byte
   always_comb begin : div_hi
      logic [DIV_W-1:0] r;
      r        = DIV_W'(column_ff) + DIV_W'(data_byte);
      div_q_hi = '0;
      for (int k = DIV_HI_W + DIV_LO_W - 1; k >= DIV_LO_W; k--) begin
         if (r >= (DIV_W'(width_ff) << k)) begin
            r                     = r - (DIV_W'(width_ff) << k);
            div_q_hi[k - DIV_LO_W] = 1'b1;
         end
      end
      div_rem_hi = r[rle8d_pkg::DIM_W-1:0];
   end

   // lower quotient bits on the dy byte
   always_comb begin : div_lo
      logic [DIV_W-1:0] r;
      r        = DIV_W'(div_rem_ff);
      div_q_lo = '0;
      for (int k = DIV_LO_W - 1; k >= 0; k--) begin
         if (r >= (DIV_W'(width_ff) << k)) begin
            r           = r - (DIV_W'(width_ff) << k);
            div_q_lo[k] = 1'b1;
         end
      end
      div_rem_lo = r[rle8d_pkg::COL_W-1:0];
   end

   assign delta_mul = MUL_W'(width_ff) * MUL_W'(data_byte);
   assign delta_len = rle8d_pkg::LEN_W'(delta_mul) + rle8d_pkg::LEN_W'(delta_cols_ff);
   assign row_sum   = row_ff + rle8d_pkg::DIM_W'(data_byte)
                    + rle8d_pkg::DIM_W'({div_qhi_ff, div_q_lo});

   assign cfg_w = (csr.index == rle8d_pkg::CSR_IMAGE_WIDTH)
                ? saturate(csr.data, rle8d_pkg::DIM_W'(rle8d_pkg::MAX_WIDTH)) : width_ff;
   assign cfg_h = (csr.index == rle8d_pkg::CSR_IMAGE_HEIGHT)
                ? saturate(csr.data, rle8d_pkg::DIM_W'(rle8d_pkg::MAX_HEIGHT)) : height_ff;
   assign cfg_area = rle8d_pkg::LEN_W'(cfg_w) * rle8d_pkg::LEN_W'(cfg_h);

   always_comb begin
      phase_in      = phase_ff;
      held_in       = held_ff;
      abs_left_in   = abs_left_ff;
      skip_left_in  = skip_left_ff;
      delta_cols_in = delta_cols_ff;
      div_rem_in    = div_rem_ff;
      div_qhi_in    = div_qhi_ff;
      column_in     = column_ff;
      row_in        = row_ff;
      finished_in   = finished_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      pix_left_in   = pix_left_ff;
      have          = 1'b0;
      done          = 1'b0;
      idx           = '0;
      len           = '0;

      if (step && !finished_ff) begin
         case (phase_ff)
            PH_VALUE: begin
               have = 1'b1;
               idx  = data_byte;
               if (row_ff < height_ff) begin
                  if (rle8d_pkg::DIM_W'(held_ff) >= row_left) begin
                     len       = rle8d_pkg::LEN_W'(row_left);
                     column_in = '0;
                     row_in    = row_ff + rle8d_pkg::DIM_W'(1);
                  end else begin
                     len       = rle8d_pkg::LEN_W'(held_ff);
                     column_in = column_ff + rle8d_pkg::COL_W'(held_ff);
                  end
               end
               phase_in = PH_COUNT;
            end
            PH_CODE: begin
               case (data_byte)
                  rle8d_pkg::ESC_EOL: begin
                     if (column_ff != '0 && row_ff < height_ff) begin
                        have      = 1'b1;
                        len       = rle8d_pkg::LEN_W'(row_left);
                        column_in = '0;
                        row_in    = row_ff + rle8d_pkg::DIM_W'(1);
                     end
                     phase_in = PH_COUNT;
                  end
                  rle8d_pkg::ESC_EOB: begin
                     have      = 1'b1;
                     done      = 1'b1;
                     len       = pix_left_ff;
                     column_in = '0;
                     row_in    = height_ff;
                     phase_in  = PH_COUNT;
                  end
                  rle8d_pkg::ESC_DELTA: begin
                     phase_in = PH_DX;
                  end
                  default: begin
                     abs_left_in  = data_byte;
                     skip_left_in = (rle8d_pkg::BYTE_W+1)'(data_byte)
                                  + (rle8d_pkg::BYTE_W+1)'(data_byte[0]);
                     phase_in     = PH_ABS;
                  end
               endcase
            end
            PH_DX: begin
               delta_cols_in = data_byte;
               div_rem_in    = div_rem_hi;
               div_qhi_in    = div_q_hi;
               phase_in      = PH_DY;
            end
            PH_DY: begin
               have = 1'b1;
               if (delta_len >= pix_left_ff) begin
                  len       = pix_left_ff;
                  column_in = '0;
                  row_in    = height_ff;
               end else begin
                  len       = delta_len;
                  column_in = div_rem_lo;
                  row_in    = row_sum;
               end
               phase_in = PH_COUNT;
            end
            PH_ABS: begin
               if (skip_left_ff != '0)
                  skip_left_in = skip_left_ff - (rle8d_pkg::BYTE_W+1)'(1);
               if (abs_left_ff != '0) begin
                  abs_left_in = abs_left_ff - rle8d_pkg::BYTE_W'(1);
                  if (row_ff < height_ff) begin
                     have = 1'b1;
                     idx  = data_byte;
                     len  = rle8d_pkg::LEN_W'(1);
                     if (rle8d_pkg::DIM_W'(column_ff) + rle8d_pkg::DIM_W'(1) == width_ff) begin
                        column_in   = '0;
                        row_in      = row_ff + rle8d_pkg::DIM_W'(1);
                        abs_left_in = '0;
                     end else begin
                        column_in = column_ff + rle8d_pkg::COL_W'(1);
                     end
                  end else begin
                     abs_left_in = '0;
                  end
               end
               if (skip_left_in == '0) phase_in = PH_COUNT;
            end
            default: begin
               if (data_byte != rle8d_pkg::ESC_BYTE) begin
                  held_in  = data_byte;
                  phase_in = PH_VALUE;
               end else begin
                  phase_in = PH_CODE;
               end
            end
         endcase
         if (last_byte) done = 1'b1;
         if (done) finished_in = 1'b1;
         pix_left_in = pix_left_ff - len;
      end

      // size write: restart decoding
      if (csr.wr_en) begin
         phase_in     = PH_COUNT;
         held_in      = '0;
         abs_left_in  = '0;
         skip_left_in = '0;
         column_in    = '0;
         row_in       = '0;
         finished_in  = 1'b0;
         width_in     = cfg_w;
         height_in    = cfg_h;
         pix_left_in  = cfg_area;
      end
   end

   assign res_valid       = step && !finished_ff && (have || done);
   assign res.pixel_index = idx;
   assign res.run_length  = len;
   assign res.image_done  = done;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_COUNT;
         held_ff      <= '0;
         abs_left_ff  <= '0;
         skip_left_ff <= '0;
         column_ff    <= '0;
         row_ff       <= '0;
         finished_ff  <= 1'b0;
         width_ff     <= rle8d_pkg::DIM_W'(1);
         height_ff    <= rle8d_pkg::DIM_W'(1);
         pix_left_ff  <= rle8d_pkg::LEN_W'(1);
      end else begin
         phase_ff     <= phase_in;
         held_ff      <= held_in;
         abs_left_ff  <= abs_left_in;
         skip_left_ff <= skip_left_in;
         column_ff    <= column_in;
         row_ff       <= row_in;
         finished_ff  <= finished_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         pix_left_ff  <= pix_left_in;
      end
   end

   always_ff @(posedge clock) begin
      delta_cols_ff <= delta_cols_in;
      div_rem_ff    <= div_rem_in;
      div_qhi_ff    <= div_qhi_in;
   end

`ifndef ASSERT_OFF
   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      row_ff <= height_ff)
      else $error("row beyond image height");

   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      rle8d_pkg::DIM_W'(column_ff) < width_ff)
      else $error("column beyond image width");

   a_end_col_zero: assert property (@(posedge clock) disable iff (reset)
      (row_ff == height_ff) |-> (column_ff == '0))
      else $error("position past image end");

   a_finished_quiet: assert property (@(posedge clock) disable iff (reset)
      finished_ff |-> !res_valid)
      else $error("run word after decoding finished");
`endif

endmodule

### rtl/rle8_bitmap_decoder_core.sv
// ----------------------------------------------------------------------------
// RLE8 bitmap decoder core
// Decodes an RLE8 compressed bitmap byte stream into runs of palette indices.
// ----------------------------------------------------------------------------
// Takes one compressed byte per clock while req ready is high and registers
// its run word, if any, in the output buffer. All work on a byte is done in
// a single pass through the decode engine; the delta escape splits its column
// division over its dx and dy bytes. A two-word output buffer keeps the input
// open while one run word waits; req ready drops only when both buffer words
// are full, and stays low during reset. A write to either size register
// restarts decoding at once; make it only while no word is in flight.
module rle8_bitmap_decoder_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [rle8d_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rle8d_pkg::DIM_W-1:0]       csr_wr_data,
   rle8d_req_if.sink                         req_bus,
   rle8d_rsp_if.source                       rsp_bus
);

   rle8d_pkg::csr_write_type csr;
   rle8d_pkg::result_type    res;
   rle8d_pkg::result_type    rsp_data_ff, rsp_data_in;
   rle8d_pkg::result_type    skid_data_ff, skid_data_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     skid_valid_ff, skid_valid_in;
   logic                     res_valid;
   logic                     step;

   assign csr.wr_en = csr_wr_en;
   assign csr.index = csr_index;
   assign csr.data  = csr_wr_data;

   assign req_bus.ready = !skid_valid_ff && !reset;
   assign step          = req_bus.valid && req_bus.ready;

   rle8d_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .step      (step),
      .data_byte (req_bus.data_byte),
      .last_byte (req_bus.last_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (rsp_bus.ready) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!rsp_valid_ff || rsp_bus.ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) rsp_data_in = res;
      end else if (res_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.pixel_index = rsp_data_ff.pixel_index;
   assign rsp_bus.run_length  = rsp_data_ff.run_length;
   assign rsp_bus.image_done  = rsp_data_ff.image_done;

`ifndef ASSERT_OFF
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid word held with empty output register");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("run word changed while stalled");
`endif

endmodule
